### src/dssc_pkg.sv
// dssc_pkg: shared types, opcodes and codes for the debug step/stop controller
// depends on nothing; used by every module in src

package dssc_pkg;

	// apb address width: eight 32-bit registers at byte offsets 0..28
	localparam int unsigned AddrWidth = 5;
	localparam int unsigned DataWidth = 32;

	// opcodes that matter for call tracking
	localparam logic [7:0] OpJsr    = 8'h20;
	localparam logic [7:0] OpRts    = 8'h60;
	localparam logic [7:0] OpRti    = 8'h40;
	localparam logic [7:0] OpJmp    = 8'h4C;
	localparam logic [7:0] OpJmpInd = 8'h6C;
	localparam logic [7:0] OpJmpIdx = 8'h7C;

	// stack bytes pushed by a call
	localparam logic [7:0] ReturnAddressBytes = 8'd2;

	// run kinds
	localparam logic [2:0] KindRunTo    = 3'd0;
	localparam logic [2:0] KindStepInto = 3'd1;
	localparam logic [2:0] KindTrace    = 3'd2;
	localparam logic [2:0] KindStepOver = 3'd3;
	localparam logic [2:0] KindStepOut  = 3'd4;
	localparam logic [2:0] KindGo       = 3'd5;

	// stop reasons
	localparam logic [2:0] ReasonPause      = 3'd0;
	localparam logic [2:0] ReasonRunTo      = 3'd1;
	localparam logic [2:0] ReasonStep       = 3'd2;
	localparam logic [2:0] ReasonBreakpoint = 3'd3;
	localparam logic [2:0] ReasonWatchpoint = 3'd4;

	// request types
	localparam logic [1:0] ReqBegin = 2'd0;
	localparam logic [1:0] ReqCheck = 2'd1;
	localparam logic [1:0] ReqEnd   = 2'd2;

	// register indexes
	localparam logic [2:0] RegRunKind      = 3'd0;
	localparam logic [2:0] RegStepCount    = 3'd1;
	localparam logic [2:0] RegUntilEnable  = 3'd2;
	localparam logic [2:0] RegUntilAddress = 3'd3;
	localparam logic [2:0] RegSkipEnable   = 3'd4;
	localparam logic [2:0] RegSkipFirst    = 3'd5;
	localparam logic [2:0] RegSkipLast     = 3'd6;
	localparam logic [2:0] RegSourceMode   = 3'd7;

	typedef struct packed {
		logic [2:0]  run_kind;
		logic [15:0] step_count;
		logic        until_enable;
		logic [15:0] until_address;
		logic        skip_enable;
		logic [15:0] skip_first;
		logic [15:0] skip_last;
		logic        source_mode;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] pc;
		logic [7:0]  sp;
		logic [7:0]  opcode;
		logic        line_valid;
		logic [15:0] line_id;
		logic        in_step_filter;
		logic        breakpoint_hit;
		logic        watch_pending;
	} item_t;

	typedef struct packed {
		logic       stop_before;
		logic       pending_stop;
		logic [2:0] stop_reason;
		logic       run_active;
	} result_t;

	// returns, interrupt returns and jumps leave a called routine
	function automatic logic is_transfer(input logic [7:0] op);
		return (op == OpRts) || (op == OpRti) || (op == OpJmp) ||
			(op == OpJmpInd) || (op == OpJmpIdx);
	endfunction

endpackage

### src/debug_step_stop_controller.sv
// debug_step_stop_controller: debug run/step stop controller, top level
// path: each accepted item passes the input register, then the result register
// throughput: one item per cycle while out_stall does not hold the result register
// reset: arst_n clears run state, pipeline valids and loads register defaults
// depends on dssc_pkg, dssc_cfg_regs, dssc_core

module debug_step_stop_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	// apb configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dssc_pkg::AddrWidth-1:0]  paddr,
	input  logic [dssc_pkg::DataWidth-1:0]  pwdata,
	output logic [dssc_pkg::DataWidth-1:0]  prdata,
	output logic                            pready,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      req_type,
	input  logic [15:0]                     pc,
	input  logic [7:0]                      sp,
	input  logic [7:0]                      opcode,
	input  logic                            line_valid,
	input  logic [15:0]                     line_id,
	input  logic                            in_step_filter,
	input  logic                            breakpoint_hit,
	input  logic                            watch_pending,
	// output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            stop_before,
	output logic                            pending_stop,
	output logic [2:0]                      stop_reason,
	output logic                            run_active
);

	dssc_pkg::cfg_t    cfg;
	dssc_pkg::item_t   item_s1;
	dssc_pkg::result_t result_comb, result_s2;
	logic              valid_s1, valid_s2, out_free, advance, take_in;

	assign pready = 1'b1;

	dssc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// pipeline flow control
	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign take_in  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take_in)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.req_type       <= req_type;
			item_s1.pc             <= pc;
			item_s1.sp             <= sp;
			item_s1.opcode         <= opcode;
			item_s1.line_valid     <= line_valid;
			item_s1.line_id        <= line_id;
			item_s1.in_step_filter <= in_step_filter;
			item_s1.breakpoint_hit <= breakpoint_hit;
			item_s1.watch_pending  <= watch_pending;
		end
	end

	dssc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (out_free)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_s2 <= result_comb;
	end

	assign out_valid    = valid_s2;
	assign stop_before  = result_s2.stop_before;
	assign pending_stop = result_s2.pending_stop;
	assign stop_reason  = result_s2.stop_reason;
	assign run_active   = result_s2.run_active;

endmodule

### src/dssc_cfg_regs.sv
// dssc_cfg_regs: apb register file holding the run configuration
// depends on dssc_pkg

module dssc_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dssc_pkg::AddrWidth-1:0]  paddr,
	input  logic [dssc_pkg::DataWidth-1:0]  pwdata,
	output logic [dssc_pkg::DataWidth-1:0]  prdata,
	output dssc_pkg::cfg_t                  cfg
);

	dssc_pkg::cfg_t cfg_q;
	logic [2:0]     reg_index;
	logic           wr_en;

	assign reg_index = paddr[4:2];
	assign wr_en     = psel && penable && pwrite;
	assign cfg       = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_kind      <= dssc_pkg::KindRunTo;
			cfg_q.step_count    <= 16'd1;
			cfg_q.until_enable  <= 1'b0;
			cfg_q.until_address <= 16'd0;
			cfg_q.skip_enable   <= 1'b0;
			cfg_q.skip_first    <= 16'd0;
			cfg_q.skip_last     <= 16'd0;
			cfg_q.source_mode   <= 1'b0;
		end else if (wr_en) begin
			case (reg_index)
				dssc_pkg::RegRunKind:      cfg_q.run_kind      <= pwdata[2:0];
				dssc_pkg::RegStepCount:    cfg_q.step_count    <= pwdata[15:0];
				dssc_pkg::RegUntilEnable:  cfg_q.until_enable  <= pwdata[0];
				dssc_pkg::RegUntilAddress: cfg_q.until_address <= pwdata[15:0];
				dssc_pkg::RegSkipEnable:   cfg_q.skip_enable   <= pwdata[0];
				dssc_pkg::RegSkipFirst:    cfg_q.skip_first    <= pwdata[15:0];
				dssc_pkg::RegSkipLast:     cfg_q.skip_last     <= pwdata[15:0];
				dssc_pkg::RegSourceMode:   cfg_q.source_mode   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_index)
			dssc_pkg::RegRunKind:      prdata = {29'd0, cfg_q.run_kind};
			dssc_pkg::RegStepCount:    prdata = {16'd0, cfg_q.step_count};
			dssc_pkg::RegUntilEnable:  prdata = {31'd0, cfg_q.until_enable};
			dssc_pkg::RegUntilAddress: prdata = {16'd0, cfg_q.until_address};
			dssc_pkg::RegSkipEnable:   prdata = {31'd0, cfg_q.skip_enable};
			dssc_pkg::RegSkipFirst:    prdata = {16'd0, cfg_q.skip_first};
			dssc_pkg::RegSkipLast:     prdata = {16'd0, cfg_q.skip_last};
			dssc_pkg::RegSourceMode:   prdata = {31'd0, cfg_q.source_mode};
			default:                   prdata = '0;
		endcase
	end

endmodule

### src/dssc_core.sv
// dssc_core: run state and the single-pass stop decision for one item
// depends on dssc_pkg

module dssc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  dssc_pkg::item_t   item,
	input  dssc_pkg::cfg_t    cfg,
	output dssc_pkg::result_t result
);

	// run state
	logic        active_q, stopped_q, over_call_q, call_valid_q, start_line_valid_q;
	logic [2:0]  reason_q;
	logic [15:0] exec_count_q, start_line_q;
	logic [7:0]  start_stack_q, prev_op_q, call_level_q;

	// next state
	logic        active_d, stopped_d, over_call_d, call_valid_d, start_line_valid_d;
	logic [2:0]  reason_d;
	logic [15:0] exec_count_d, start_line_d;
	logic [7:0]  start_stack_d, prev_op_d, call_level_d;
	logic        stop_before_d;

	// decision terms
	logic        kind_into, first, tracking, leave_call, level_set, call_valid_t;
	logic [7:0]  call_level_t;
	logic        left_skip, new_line, complete, stop_done, stop_bp, stop_flag;

	assign kind_into = (cfg.run_kind == dssc_pkg::KindStepInto) ||
		(cfg.run_kind == dssc_pkg::KindTrace);
	assign first     = active_q && (exec_count_q == 16'd0);
	assign tracking  = active_q && !first;

	// call tracking by stack level
	assign leave_call = call_valid_q && (item.sp >= call_level_q) &&
		dssc_pkg::is_transfer(prev_op_q);
	assign level_set  = !(call_valid_q && !leave_call) && (prev_op_q == dssc_pkg::OpJsr) &&
		((cfg.run_kind == dssc_pkg::KindStepOver) || (kind_into && item.in_step_filter));
	assign call_valid_t = tracking ? ((call_valid_q && !leave_call) || level_set)
		: call_valid_q;
	assign call_level_t = (tracking && level_set) ?
		(item.sp + dssc_pkg::ReturnAddressBytes) : call_level_q;

	// completion test
	assign left_skip = cfg.skip_enable &&
		((item.pc < cfg.skip_first) || (item.pc > cfg.skip_last));
	assign new_line  = item.line_valid &&
		(!start_line_valid_q || (item.line_id != start_line_q));

	always_comb begin
		complete = 1'b0;
		if (cfg.source_mode && (cfg.run_kind != dssc_pkg::KindStepOut)) begin
			if (kind_into)
				complete = new_line && !call_valid_t;
			else if (cfg.run_kind == dssc_pkg::KindStepOver)
				complete = !call_valid_t && (new_line || (item.sp > start_stack_q));
		end else begin
			case (cfg.run_kind)
				dssc_pkg::KindRunTo:
					complete = (cfg.until_enable && (item.pc == cfg.until_address)) ||
						left_skip;
				dssc_pkg::KindStepInto, dssc_pkg::KindTrace:
					complete = (exec_count_q >= cfg.step_count) && !call_valid_t;
				dssc_pkg::KindStepOver:
					complete = !over_call_q || !call_valid_t;
				dssc_pkg::KindStepOut:
					complete = (item.sp > start_stack_q) &&
						dssc_pkg::is_transfer(prev_op_q);
				dssc_pkg::KindGo:
					complete = left_skip;
				default:
					complete = 1'b0;
			endcase
		end
	end

	assign stop_done = tracking && complete;
	assign stop_bp   = !stop_done && !first && item.breakpoint_hit;
	assign stop_flag = stop_done || stop_bp;

	// next state per request type
	always_comb begin
		active_d           = active_q;
		stopped_d          = stopped_q;
		reason_d           = reason_q;
		exec_count_d       = exec_count_q;
		start_stack_d      = start_stack_q;
		prev_op_d          = prev_op_q;
		over_call_d        = over_call_q;
		call_valid_d       = call_valid_q;
		call_level_d       = call_level_q;
		start_line_valid_d = start_line_valid_q;
		start_line_d       = start_line_q;
		stop_before_d      = 1'b0;
		case (item.req_type)
			dssc_pkg::ReqBegin: begin
				active_d           = 1'b1;
				stopped_d          = 1'b0;
				reason_d           = dssc_pkg::ReasonPause;
				exec_count_d       = 16'd0;
				start_stack_d      = item.sp;
				prev_op_d          = 8'd0;
				over_call_d        = (cfg.run_kind == dssc_pkg::KindStepOver) &&
					(item.opcode == dssc_pkg::OpJsr);
				call_valid_d       = 1'b0;
				call_level_d       = 8'd0;
				start_line_valid_d = cfg.source_mode && item.line_valid;
				start_line_d       = (cfg.source_mode && item.line_valid) ?
					item.line_id : 16'd0;
			end
			dssc_pkg::ReqEnd: begin
				active_d  = 1'b0;
				stopped_d = 1'b0;
			end
			dssc_pkg::ReqCheck: begin
				if (!stopped_q) begin
					call_valid_d = call_valid_t;
					call_level_d = call_level_t;
					if (stop_done) begin
						stopped_d = 1'b1;
						reason_d  = ((cfg.run_kind == dssc_pkg::KindRunTo) ||
							(cfg.run_kind == dssc_pkg::KindGo)) ?
							dssc_pkg::ReasonRunTo : dssc_pkg::ReasonStep;
					end else if (stop_bp) begin
						stopped_d = 1'b1;
						reason_d  = dssc_pkg::ReasonBreakpoint;
					end
					if (!stop_flag && active_q) begin
						prev_op_d = item.opcode;
						if (exec_count_q != 16'hFFFF)
							exec_count_d = exec_count_q + 16'd1;
					end
				end
				stop_before_d = stopped_d;
			end
			default: ;
		endcase
	end

	// status fields after the item
	assign result.stop_before  = stop_before_d;
	assign result.pending_stop = stopped_d || item.watch_pending;
	assign result.stop_reason  = stopped_d ? reason_d :
		(item.watch_pending ? dssc_pkg::ReasonWatchpoint : dssc_pkg::ReasonPause);
	assign result.run_active   = active_d;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q           <= 1'b0;
			stopped_q          <= 1'b0;
			reason_q           <= dssc_pkg::ReasonPause;
			exec_count_q       <= 16'd0;
			start_stack_q      <= 8'd0;
			prev_op_q          <= 8'd0;
			over_call_q        <= 1'b0;
			call_valid_q       <= 1'b0;
			call_level_q       <= 8'd0;
			start_line_valid_q <= 1'b0;
			start_line_q       <= 16'd0;
		end else if (advance) begin
			active_q           <= active_d;
			stopped_q          <= stopped_d;
			reason_q           <= reason_d;
			exec_count_q       <= exec_count_d;
			start_stack_q      <= start_stack_d;
			prev_op_q          <= prev_op_d;
			over_call_q        <= over_call_d;
			call_valid_q       <= call_valid_d;
			call_level_q       <= call_level_d;
			start_line_valid_q <= start_line_valid_d;
			start_line_q       <= start_line_d;
		end
	end

endmodule

### sim/tb_top.sv
// tb_top: self-checking testbench for debug_step_stop_controller
// holds a scoreboard class that predicts each result, plus tasks that drive the item and apb ports
// depends on dssc_pkg and debug_step_stop_controller from src
`timescale 1ns / 100ps

import dssc_pkg::*;

// predicts the controller's answer to every accepted item and checks the results in order
class stop_scoreboard;
	cfg_t        regs;
	logic        running;
	logic        halted;
	logic        over_jsr;
	logic        return_armed;
	logic        entry_line_known;
	logic [2:0]  why;
	logic [15:0] steps_done;
	logic [15:0] entry_line;
	logic [7:0]  entry_stack;
	logic [7:0]  last_op;
	logic [7:0]  return_level;
	result_t     awaited[$];
	int          mismatches;

	function new();
		regs = '0;
		regs.step_count = 16'd1;
		running = 1'b0;
		halted = 1'b0;
		over_jsr = 1'b0;
		return_armed = 1'b0;
		entry_line_known = 1'b0;
		why = ReasonPause;
		steps_done = '0;
		entry_line = '0;
		entry_stack = '0;
		last_op = '0;
		return_level = '0;
		mismatches = 0;
	endfunction

	function void apply_register(logic [2:0] idx, logic [31:0] value);
		case (idx)
			RegRunKind:      regs.run_kind = value[2:0];
			RegStepCount:    regs.step_count = value[15:0];
			RegUntilEnable:  regs.until_enable = value[0];
			RegUntilAddress: regs.until_address = value[15:0];
			RegSkipEnable:   regs.skip_enable = value[0];
			RegSkipFirst:    regs.skip_first = value[15:0];
			RegSkipLast:     regs.skip_last = value[15:0];
			RegSourceMode:   regs.source_mode = value[0];
			default: ;
		endcase
	endfunction

	// returns and jumps end a called routine
	function logic leaves_routine(logic [7:0] op);
		case (op)
			OpRts, OpRti, OpJmp, OpJmpInd, OpJmpIdx: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// arm or drop the awaited return level of a call
	function void follow_calls(logic filtered, logic [7:0] stack);
		logic into;
		into = regs.run_kind == KindStepInto || regs.run_kind == KindTrace;
		if (return_armed && stack >= return_level && leaves_routine(last_op))
			return_armed = 1'b0;
		if (!return_armed && last_op == OpJsr &&
				(regs.run_kind == KindStepOver || (into && filtered))) begin
			return_level = stack + ReturnAddressBytes;
			return_armed = 1'b1;
		end
	endfunction

	// completion test for the current run kind
	function logic run_done(item_t it);
		logic left_range;
		logic fresh_line;
		logic into;
		left_range = regs.skip_enable && (it.pc < regs.skip_first || it.pc > regs.skip_last);
		into = regs.run_kind == KindStepInto || regs.run_kind == KindTrace;
		if (regs.source_mode && regs.run_kind != KindStepOut) begin
			fresh_line = it.line_valid && (!entry_line_known || it.line_id != entry_line);
			if (into)
				return fresh_line && !return_armed;
			if (regs.run_kind == KindStepOver)
				return !return_armed && (fresh_line || it.sp > entry_stack);
			return 1'b0;
		end
		case (regs.run_kind)
			KindRunTo:               return (regs.until_enable && it.pc == regs.until_address) ||
						left_range;
			KindStepInto, KindTrace: return steps_done >= regs.step_count && !return_armed;
			KindStepOver:            return !over_jsr || !return_armed;
			KindStepOut:             return it.sp > entry_stack && leaves_routine(last_op);
			KindGo:                  return left_range;
			default:                 return 1'b0;
		endcase
	endfunction

	// update the run state for one accepted item and queue its expected result
	function void note_item(item_t it);
		result_t want;
		logic    halt;
		logic    opening;
		halt = 1'b0;
		case (it.req_type)
			ReqBegin: begin
				running = 1'b1;
				halted = 1'b0;
				why = ReasonPause;
				steps_done = '0;
				entry_stack = it.sp;
				last_op = '0;
				over_jsr = regs.run_kind == KindStepOver && it.opcode == OpJsr;
				return_armed = 1'b0;
				return_level = '0;
				entry_line_known = regs.source_mode && it.line_valid;
				entry_line = entry_line_known ? it.line_id : 16'd0;
			end
			ReqEnd: begin
				running = 1'b0;
				halted = 1'b0;
			end
			ReqCheck: begin
				if (!halted) begin
					// the first check after a begin only counts the instruction
					opening = running && steps_done == 16'd0;
					if (running && !opening)
						follow_calls(it.in_step_filter, it.sp);
					if (running && !opening && run_done(it)) begin
						halted = 1'b1;
						why = (regs.run_kind == KindRunTo || regs.run_kind == KindGo) ?
							ReasonRunTo : ReasonStep;
					end else if (!opening && it.breakpoint_hit) begin
						halted = 1'b1;
						why = ReasonBreakpoint;
					end
					if (!halted && running) begin
						last_op = it.opcode;
						if (steps_done != 16'hFFFF)
							steps_done = steps_done + 16'd1;
					end
				end
				halt = halted;
			end
			default: ;
		endcase
		want.stop_before = halt;
		want.pending_stop = halted || it.watch_pending;
		want.stop_reason = halted ? why : (it.watch_pending ? ReasonWatchpoint : ReasonPause);
		want.run_active = running;
		awaited.push_back(want);
	endfunction

	function void check_result(result_t got);
		result_t want;
		if (awaited.size() == 0) begin
			$error("result %b arrived with no item outstanding", got);
			mismatches++;
			return;
		end
		want = awaited.pop_front();
		if (got.stop_before !== want.stop_before) begin
			$error("stop_before: expected %0d, got %0d", want.stop_before, got.stop_before);
			mismatches++;
		end
		if (got.pending_stop !== want.pending_stop) begin
			$error("pending_stop: expected %0d, got %0d", want.pending_stop, got.pending_stop);
			mismatches++;
		end
		if (got.stop_reason !== want.stop_reason) begin
			$error("stop_reason: expected %0d, got %0d", want.stop_reason, got.stop_reason);
			mismatches++;
		end
		if (got.run_active !== want.run_active) begin
			$error("run_active: expected %0d, got %0d", want.run_active, got.run_active);
			mismatches++;
		end
	endfunction

	function int outstanding();
		return awaited.size();
	endfunction

	function logic clean();
		return mismatches == 0 && awaited.size() == 0;
	endfunction
endclass

module tb_top;

	localparam logic [1:0] ReqUnused   = 2'd3;
	localparam int         RandomItems = 1950;
	localparam int         CycleLimit  = 2000000;
	localparam int         Latency     = 2;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [AddrWidth-1:0] paddr = '0;
	logic [DataWidth-1:0] pwdata = '0;
	logic [DataWidth-1:0] prdata;
	logic                 pready;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           req_type = '0;
	logic [15:0]          pc = '0;
	logic [7:0]           sp = '0;
	logic [7:0]           opcode = '0;
	logic                 line_valid = 1'b0;
	logic [15:0]          line_id = '0;
	logic                 in_step_filter = 1'b0;
	logic                 breakpoint_hit = 1'b0;
	logic                 watch_pending = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 stop_before;
	logic                 pending_stop;
	logic [2:0]           stop_reason;
	logic                 run_active;

	stop_scoreboard sb = new();
	logic           calm = 1'b1;
	int             counted = 0;
	int             cycles = 0;

	debug_step_stop_controller uut (.*);

	always #5 clk = ~clk;

	// run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("debug_step_stop_controller verification failed");
			$finish;
		end
	end

	// check every result the block hands over
	always @(posedge clk) begin : take_results
		result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.stop_before = stop_before;
			got.pending_stop = pending_stop;
			got.stop_reason = stop_reason;
			got.run_active = run_active;
			sb.check_result(got);
		end
	end

	// mostly short, occasionally long
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// receiver back-pressure
	initial begin : stall_gen
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (calm) begin
				out_stall <= 1'b0;
				hold = 0;
			end else if (hold > 0) begin
				hold--;
			end else if ($urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				hold = pause_len() - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// present one item, hold it until accepted, then record it
	task automatic send_item(input item_t it);
		int gap;
		gap = (calm || $urandom_range(0, 2) != 0) ? 0 : pause_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= it.req_type;
		pc <= it.pc;
		sp <= it.sp;
		opcode <= it.opcode;
		line_valid <= it.line_valid;
		line_id <= it.line_id;
		in_step_filter <= it.in_step_filter;
		breakpoint_hit <= it.breakpoint_hit;
		watch_pending <= it.watch_pending;
		do @(posedge clk); while (in_stall);
		sb.note_item(it);
		if (it.req_type != ReqUnused)
			counted++;
	endtask

	// stop sending and let every outstanding result come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (Latency + 1) @(posedge clk);
	endtask

	// apb write: setup phase then access phase
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.apply_register(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic item_t make_item(logic [1:0] req, logic [15:0] at, logic [7:0] stack,
			logic [7:0] op, logic lv, logic [15:0] lid, logic filt, logic bp, logic watch);
		item_t it;
		it.req_type = req;
		it.pc = at;
		it.sp = stack;
		it.opcode = op;
		it.line_valid = lv;
		it.line_id = lid;
		it.in_step_filter = filt;
		it.breakpoint_hit = bp;
		it.watch_pending = watch;
		return it;
	endfunction

	function automatic item_t noise_item();
		return make_item(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom), 8'($urandom),
			1'($urandom), 16'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
	endfunction

	// call, return and jump opcodes show up often
	function automatic logic [7:0] pick_opcode();
		case ($urandom_range(0, 9))
			0, 1: return OpJsr;
			2:    return OpRts;
			3:    return OpRti;
			4: begin
				case ($urandom_range(0, 2))
					0:       return OpJmp;
					1:       return OpJmpInd;
					default: return OpJmpIdx;
				endcase
			end
			default: return 8'($urandom);
		endcase
	endfunction

	// instruction item with source lines mostly drawn from a small set
	function automatic item_t step_item(logic [1:0] req, logic [15:0] at, logic [7:0] stack,
			logic [7:0] op, logic [15:0] line_base);
		logic [15:0] lid;
		lid = ($urandom_range(0, 4) == 0) ? 16'($urandom) : line_base + 16'($urandom_range(0, 2));
		return make_item(req, at, stack, op, $urandom_range(0, 3) != 0, lid, 1'($urandom),
			$urandom_range(0, 15) == 0, $urandom_range(0, 9) == 0);
	endfunction

	// one begin, a plausible instruction stream, and usually an end
	task automatic play_run(input logic [15:0] base, input logic [15:0] line_base);
		logic [15:0] at;
		logic [7:0]  stack;
		logic [7:0]  op;
		at = base;
		stack = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 3)) :
			8'($urandom_range(8'hC0, 8'hFF));
		op = pick_opcode();
		send_item(step_item(ReqBegin, at, stack, op, line_base));
		repeat ($urandom_range(1, 25)) begin
			// move pc and stack the way the executed opcode would
			case (op)
				OpJsr: begin
					stack = stack - ReturnAddressBytes;
					at = base + 16'($urandom_range(0, 40));
				end
				OpRts: begin
					stack = stack + ReturnAddressBytes;
					at = at + 16'($urandom_range(1, 6));
				end
				OpRti: begin
					stack = stack + 8'd3;
					at = base + 16'($urandom_range(0, 40));
				end
				OpJmp, OpJmpInd, OpJmpIdx: at = base + 16'($urandom_range(0, 40));
				default: begin
					at = at + 16'($urandom_range(1, 3));
					if ($urandom_range(0, 4) == 0)
						stack = stack + 8'($urandom_range(0, 2)) - 8'd1;
				end
			endcase
			op = pick_opcode();
			send_item(step_item(ReqCheck, at, stack, op, line_base));
			if ($urandom_range(0, 59) == 0)
				drain();
		end
		if ($urandom_range(0, 9) < 7)
			send_item(step_item(ReqEnd, at, stack, op, line_base));
	endtask

	// settings aimed at the address region the runs will use
	task automatic random_setup(input logic [15:0] base);
		logic [15:0] lo;
		logic [15:0] hi;
		write_reg(RegRunKind, ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) :
			$urandom_range(0, 5));
		case ($urandom_range(0, 5))
			0:       write_reg(RegStepCount, 32'h0000);
			1:       write_reg(RegStepCount, 32'hFFFF);
			2:       write_reg(RegStepCount, 32'(16'($urandom)));
			default: write_reg(RegStepCount, $urandom_range(1, 12));
		endcase
		write_reg(RegUntilEnable, $urandom_range(0, 1));
		write_reg(RegUntilAddress, ($urandom_range(0, 3) == 0) ? 32'(16'($urandom)) :
			32'(base + 16'($urandom_range(0, 30))));
		write_reg(RegSkipEnable, $urandom_range(0, 1));
		case ($urandom_range(0, 7))
			0: begin
				lo = 16'h0000;
				hi = 16'hFFFF;
			end
			1: begin
				lo = 16'($urandom);
				hi = 16'($urandom);
			end
			default: begin
				lo = base - 16'($urandom_range(0, 4));
				hi = base + 16'($urandom_range(0, 30));
			end
		endcase
		write_reg(RegSkipFirst, 32'(lo));
		write_reg(RegSkipLast, 32'(hi));
		write_reg(RegSourceMode, 32'($urandom_range(0, 3) == 0));
	endtask

	// hand-picked cases: idle stops, call level wrap, each completion kind
	task automatic directed();
		send_item(make_item(ReqCheck, 16'h0000, 8'h00, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1));
		send_item(make_item(ReqCheck, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b0));
		send_item(make_item(ReqUnused, 16'h1234, 8'h10, 8'hEA, 1'b1, 16'h0042, 1'b0, 1'b0, 1'b1));
		send_item(make_item(ReqEnd, 16'h0000, 8'h00, 8'h00, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0));
		drain();
		// step over a call whose return level wraps past zero
		write_reg(RegRunKind, 32'(KindStepOver));
		send_item(make_item(ReqBegin, 16'h0200, 8'h01, OpJsr, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0));
		send_item(make_item(ReqCheck, 16'h0200, 8'h01, OpJsr, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0));
		send_item(make_item(ReqCheck, 16'h0300, 8'hFF, OpRts, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0));
		send_item(make_item(ReqCheck, 16'h0203, 8'h01, 8'hEA, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0));
		send_item(make_item(ReqEnd, 16'h0203, 8'h01, 8'hEA, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0));
		drain();
		// step out on a return above the entry stack
		write_reg(RegRunKind, 32'(KindStepOut));
		send_item(make_item(ReqBegin, 16'h0400, 8'h80, 8'hEA, 1'b1, 16'h0007, 1'b0, 1'b0, 1'b0));
		send_item(make_item(ReqCheck, 16'h0400, 8'h80, 8'hEA, 1'b1, 16'h0007, 1'b0, 1'b0, 1'b0));
		send_item(make_item(ReqCheck, 16'h0401, 8'h80, OpRts, 1'b1, 16'h0008, 1'b0, 1'b0, 1'b0));
		send_item(make_item(ReqCheck, 16'h0600, 8'h82, 8'hEA, 1'b1, 16'h0009, 1'b0, 1'b0, 1'b0));
		drain();
		// zero step count: completion wins over a breakpoint
		write_reg(RegRunKind, 32'(KindStepInto));
		write_reg(RegStepCount, 32'h0000);
		send_item(make_item(ReqBegin, 16'h0500, 8'h90, 8'hEA, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0));
		send_item(make_item(ReqCheck, 16'h0500, 8'h90, 8'hEA, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b0));
		send_item(make_item(ReqCheck, 16'h0501, 8'h90, 8'hEA, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b0));
		drain();
		// run to the top address
		write_reg(RegRunKind, 32'(KindRunTo));
		write_reg(RegUntilEnable, 32'd1);
		write_reg(RegUntilAddress, 32'hFFFF);
		send_item(make_item(ReqBegin, 16'hFFFE, 8'hA0, 8'hEA, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0));
		send_item(make_item(ReqCheck, 16'hFFFE, 8'hA0, 8'hEA, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0));
		send_item(make_item(ReqCheck, 16'hFFFF, 8'hA0, 8'hEA, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0));
		drain();
		// go with source stepping never completes on its own
		write_reg(RegRunKind, 32'(KindGo));
		write_reg(RegSkipEnable, 32'd1);
		write_reg(RegSkipFirst, 32'h0100);
		write_reg(RegSkipLast, 32'h0100);
		write_reg(RegSourceMode, 32'd1);
		send_item(make_item(ReqBegin, 16'h0100, 8'hB0, 8'hEA, 1'b1, 16'h0011, 1'b0, 1'b0, 1'b0));
		send_item(make_item(ReqCheck, 16'h0100, 8'hB0, 8'hEA, 1'b1, 16'h0011, 1'b0, 1'b0, 1'b0));
		send_item(make_item(ReqCheck, 16'h9000, 8'hB0, 8'hEA, 1'b1, 16'h0012, 1'b0, 1'b0, 1'b0));
		drain();
	endtask

	initial begin : stimulus
		logic [15:0] base;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		calm = 1'b1;
		directed();
		// random phases: new settings, then runs or noise
		counted = 0;
		while (counted < RandomItems) begin
			drain();
			calm = $urandom_range(0, 3) == 0;
			case ($urandom_range(0, 7))
				0:       base = 16'h0000;
				1:       base = 16'hFFE0;
				default: base = 16'($urandom);
			endcase
			random_setup(base);
			if ($urandom_range(0, 6) == 0) begin
				repeat ($urandom_range(5, 30)) send_item(noise_item());
			end else begin
				repeat ($urandom_range(1, 3)) play_run(base, 16'($urandom));
			end
		end
		drain();
		repeat (10) @(posedge clk);
		if (sb.clean())
			$display("debug_step_stop_controller verification clean");
		else
			$display("debug_step_stop_controller verification failed");
		$finish;
	end

endmodule

### debug_step_stop_controller.f
src/dssc_pkg.sv
src/dssc_cfg_regs.sv
src/dssc_core.sv
src/debug_step_stop_controller.sv
sim/tb_top.sv
